@@ src/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Payload and register field widths
  localparam int SLOT_W  = 10;
  localparam int CNT_W   = 11;

  // APB port geometry: one 32-bit register at byte address 0
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_SLOT_COUNT = 1'b0;

  // Reset value of slot_count
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  // Request kinds
  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

endpackage

@@ src/bsa_bitmap_ram.sv @@
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Usage bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram #(
  parameter int WORD_BITS = 32,
  parameter int DEPTH     = 32,
  parameter int AW        = 5
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bsa_ffz.sv @@
// ----------------------------------------------------------------------------
// bsa_ffz
// Find-first-zero: lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bsa_ffz #(
  parameter int WORD_BITS = 32,
  parameter int BW        = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 found_o,
  output logic [BW-1:0]        bit_o
);

  // priority pick, lowest index wins
  always_comb begin
    bit_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        bit_o = BW'(i);
      end
    end
  end

  assign found_o = ~&word_i;

endmodule

@@ src/bitmap_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// First-fit slot allocator over a usage bitmap held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------
//  in      | sink      | in_valid_i / in_stall_o     | action_i, slot_index_i
//  out     | source    | out_valid_o / out_stall_i   | granted_slot_o, ok_o
//  cfg     | sink      | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// Allocate: the scan reads bitmap words in order from word 0 and sets the lowest
// clear bit of the first word that has one, or fails at the first word that does
// not lie wholly below slot_count. Release: divide, multiply/read, write-back,
// result. The request side reopens only after the result loads into the output.
// After reset a clearing pass zeroes all MAX_SLOTS/WORD_BITS bitmap words with
// the request side stalled. A result waits while out_stall_i is high.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_unit #(
  parameter int MAX_SLOTS = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [bsa_pkg::SLOT_W-1:0]   slot_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bsa_pkg::SLOT_W-1:0]   granted_slot_o,
  output logic                         ok_o,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bsa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WCW       = $clog2(NUM_WORDS + 1);
  localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int BASE_W    = $clog2(MAX_SLOTS + WORD_BITS + 1);
  localparam int CMP_W     = (BASE_W > bsa_pkg::CNT_W + 1) ? BASE_W : bsa_pkg::CNT_W + 1;
  // reciprocal for slot_index / WORD_BITS, exact over all SLOT_W-bit inputs
  localparam int SH        = bsa_pkg::SLOT_W + BW;
  localparam int RCP_W     = bsa_pkg::SLOT_W + 1;
  localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = bsa_pkg::SLOT_W + RCP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_REL_DIV,
    ST_REL_MUL,
    ST_REL_WR,
    ST_RESP
  } state_e;

  state_e                       state_q;
  logic [bsa_pkg::CNT_W-1:0]    slot_count_q;
  logic [AW-1:0]                clr_q;
  logic [WCW-1:0]               cur_w_q;
  logic [CMP_W-1:0]             base_q;
  logic [bsa_pkg::SLOT_W-1:0]   idx_q;
  logic [bsa_pkg::SLOT_W-1:0]   quo_q;
  logic [CMP_W-1:0]             qwb_q;
  logic [bsa_pkg::SLOT_W-1:0]   res_slot_q;
  logic                         res_ok_q;
  logic                         out_valid_q;
  logic [bsa_pkg::SLOT_W-1:0]   out_slot_q;
  logic                         out_ok_q;

  // RAM port signals
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [WORD_BITS-1:0]         mem_rdata;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [WORD_BITS-1:0]         mem_wdata;

  logic                         in_acc;
  logic                         cfg_wr;
  logic                         ffz_found;
  logic [BW-1:0]                ffz_bit;
  logic [CMP_W-1:0]             sc_ext;
  logic                         word_in_use;
  logic [WCW-1:0]               nxt_w;
  logic                         nxt_w_ok;
  logic [PROD_W-1:0]            prod;
  logic                         quo_ok;
  logic                         rel_in_range;
  logic [bsa_pkg::SLOT_W-1:0]   rel_rem;
  logic [BW-1:0]                rel_bit;
  logic                         out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign sc_ext   = CMP_W'(slot_count_q);

  // ---------------- configuration register ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bsa_pkg::REG_SLOT_COUNT);
  assign prdata = (paddr[2] == bsa_pkg::REG_SLOT_COUNT) ?
                  bsa_pkg::PDATA_W'(slot_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= bsa_pkg::SLOT_COUNT_RST;
    end else if (cfg_wr) begin
      slot_count_q <= pwdata[bsa_pkg::CNT_W-1:0];
    end
  end

  // ---------------- scan datapath ----------------
  // word cur_w counts only if it lies wholly below slot_count and in the RAM
  assign word_in_use = (cur_w_q < WCW'(NUM_WORDS)) &&
                       ((base_q + CMP_W'(WORD_BITS)) <= sc_ext);
  assign nxt_w       = cur_w_q + WCW'(1);
  assign nxt_w_ok    = nxt_w < WCW'(NUM_WORDS);

  bsa_ffz #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_ffz (
    .word_i  (mem_rdata),
    .found_o (ffz_found),
    .bit_o   (ffz_bit)
  );

  // ---------------- release datapath ----------------
  // quotient by reciprocal multiply, remainder by back-multiply and subtract
  assign prod         = PROD_W'(idx_q) * PROD_W'(RECIP);
  assign quo_ok       = CMP_W'(quo_q) < CMP_W'(NUM_WORDS);
  assign rel_in_range = quo_ok && ((qwb_q + CMP_W'(WORD_BITS)) <= sc_ext);
  assign rel_rem      = idx_q - qwb_q[bsa_pkg::SLOT_W-1:0];
  assign rel_bit      = rel_rem[BW-1:0];

  // ---------------- RAM port muxing ----------------
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: begin
        mem_re = in_acc && (action_i == bsa_pkg::ACT_ALLOC);
      end
      ST_ALLOC: begin
        if (word_in_use && ffz_found) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cur_w_q);
          mem_wdata = mem_rdata | (WORD_BITS'(1) << ffz_bit);
        end else begin
          mem_re    = word_in_use && nxt_w_ok;
          mem_raddr = AW'(nxt_w);
        end
      end
      ST_REL_MUL: begin
        mem_re    = quo_ok;
        mem_raddr = AW'(quo_q);
      end
      ST_REL_WR: begin
        if (rel_in_range) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(quo_q);
          mem_wdata = mem_rdata & ~(WORD_BITS'(1) << rel_bit);
        end
      end
      default: begin
      end
    endcase
  end

  bsa_bitmap_ram #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (NUM_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // ---------------- sequencer and output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_w_q     <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      quo_q       <= '0;
      qwb_q       <= '0;
      res_slot_q  <= '0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_slot_q  <= '0;
      out_ok_q    <= 1'b0;
    end else begin
      // in ST_RESP an accepted result is replaced by the new one below
      if (out_valid_q && !out_stall_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NUM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cur_w_q <= '0;
            base_q  <= '0;
            idx_q   <= slot_index_i;
            state_q <= (action_i == bsa_pkg::ACT_ALLOC) ? ST_ALLOC : ST_REL_DIV;
          end
        end
        ST_ALLOC: begin
          if (!word_in_use) begin
            // pool exhausted
            res_slot_q <= '0;
            res_ok_q   <= 1'b0;
            state_q    <= ST_RESP;
          end else if (ffz_found) begin
            res_slot_q <= bsa_pkg::SLOT_W'(base_q + CMP_W'(ffz_bit));
            res_ok_q   <= 1'b1;
            state_q    <= ST_RESP;
          end else begin
            cur_w_q <= nxt_w;
            base_q  <= base_q + CMP_W'(WORD_BITS);
          end
        end
        ST_REL_DIV: begin
          quo_q   <= bsa_pkg::SLOT_W'(prod >> SH);
          state_q <= ST_REL_MUL;
        end
        ST_REL_MUL: begin
          qwb_q   <= CMP_W'(quo_q) * CMP_W'(WORD_BITS);
          state_q <= ST_REL_WR;
        end
        ST_REL_WR: begin
          res_slot_q <= '0;
          res_ok_q   <= rel_in_range;
          state_q    <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_slot_q  <= res_slot_q;
            out_ok_q    <= res_ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_slot_q;
  assign ok_o           = out_ok_q;

  // ---------------- assertions ----------------
`ifndef SYNTHESIS
  // a failed result carries slot zero; release results carry zero as well
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_slot_o == '0)
    else $error("failed result with non-zero slot");

  // one transaction in flight: accepting closes the request side
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // bitmap updates only from the clearing pass, allocate or release write-back
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_ALLOC || state_q == ST_REL_WR))
    else $error("unexpected bitmap write");
`endif

endmodule

@@ bench/tb_bitmap_slot_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_unit
// Self-checking bench for the first-fit slot allocator. A ledger class keeps
// its own copy of the usage bitmap and slot_count, predicts the grant or
// release outcome of every accepted request and checks each result in order.
// The bench starts with directed requests and then runs random phases at
// several pool sizes. Both channels idle in bursts, and two phases hold the
// result channel off for a long stretch.
// ----------------------------------------------------------------------------

localparam int WORD_SIZE = 32;
localparam int WORD_CNT  = 32;

typedef struct packed {
  logic [bsa_pkg::SLOT_W-1:0] granted;
  logic                       ok;
} slot_result_t;

// Ledger: predicted bitmap state plus the queue of outcomes still to arrive
class slot_ledger;
  logic [WORD_SIZE-1:0]      usage [WORD_CNT];
  logic [bsa_pkg::CNT_W-1:0] slot_count;
  slot_result_t              awaited [$];
  int                        errors;

  function new();
    foreach (usage[w]) usage[w] = '0;
    slot_count = bsa_pkg::SLOT_COUNT_RST;
    errors     = 0;
  endfunction

  function int unsigned active_words();
    int unsigned words;
    words = slot_count / WORD_SIZE;
    if (words > WORD_CNT) words = WORD_CNT;
    return words;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Work out the outcome of one accepted request and queue it
  function void note_request(bsa_pkg::action_e act, logic [bsa_pkg::SLOT_W-1:0] idx);
    slot_result_t res;
    int unsigned  words;
    bit           found;
    res   = '0;
    found = 1'b0;
    words = active_words();
    if (act == bsa_pkg::ACT_ALLOC) begin
      // first word that is not full, lowest clear bit within it
      for (int w = 0; w < words && !found; w++) begin
        if (usage[w] != '1) begin
          for (int b = 0; b < WORD_SIZE && !found; b++) begin
            if (!usage[w][b]) begin
              usage[w][b] = 1'b1;
              res.granted = bsa_pkg::SLOT_W'(w * WORD_SIZE + b);
              res.ok      = 1'b1;
              found       = 1'b1;
            end
          end
        end
      end
    end else if (idx < words * WORD_SIZE) begin
      usage[idx / WORD_SIZE][idx % WORD_SIZE] = 1'b0;
      res.ok = 1'b1;
    end
    awaited = {awaited, res};
  endfunction

  task report_mismatch(string what);
    $display("%0t ns  mismatch: %s", $time, what);
    errors++;
  endtask

  // Compare one accepted result with the oldest outcome
  task check_result(logic [bsa_pkg::SLOT_W-1:0] granted, logic ok);
    slot_result_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("result with none due: slot %0d ok %0b", granted, ok));
      return;
    end
    want = awaited.pop_front();
    if (granted !== want.granted)
      report_mismatch($sformatf("granted_slot %0d, predicted %0d", granted, want.granted));
    if (ok !== want.ok)
      report_mismatch($sformatf("ok %0b, predicted %0b", ok, want.ok));
  endtask
endclass

module tb_bitmap_slot_allocator_unit;

  localparam int LONG_HOLD_CYCLES = 300;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_action;
  logic [bsa_pkg::SLOT_W-1:0]   in_slot;
  logic                         out_valid;
  logic                         out_stall;
  logic [bsa_pkg::SLOT_W-1:0]   granted_slot;
  logic                         grant_ok;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bsa_pkg::PADDR_W-1:0]  paddr;
  logic [bsa_pkg::PDATA_W-1:0]  pwdata;
  logic [bsa_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  bit src_idle_on;
  bit sink_idle_on;
  bit long_hold_req;

  slot_ledger ledger;

  bitmap_slot_allocator_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (in_action),
    .slot_index_i   (in_slot),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_slot_o (granted_slot),
    .ok_o           (grant_ok),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      ledger.check_result(granted_slot, grant_ok);
  end

  // Result sink: random stall bursts, or one long hold-off on request
  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall    <= 1'b1;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request, with an optional gap first, until it is taken
  task automatic push_request(bsa_pkg::action_e act, logic [bsa_pkg::SLOT_W-1:0] idx);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_action <= act;
    in_slot   <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_request(act, idx);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // APB write of slot_count followed by a read-back
  task automatic write_slot_count(logic [bsa_pkg::CNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bsa_pkg::REG_SLOT_COUNT, 2'b00};
    pwdata  <= bsa_pkg::PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    ledger.slot_count = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== bsa_pkg::PDATA_W'(value))
      ledger.report_mismatch($sformatf("slot_count reads %0d, written %0d", prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase at a given pool size
  task automatic run_phase(logic [bsa_pkg::CNT_W-1:0] count, int items, int alloc_pct,
                           bit idle_on, bit hold);
    int unsigned                span;
    bsa_pkg::action_e           act;
    logic [bsa_pkg::SLOT_W-1:0] idx;
    drain();
    write_slot_count(count);
    src_idle_on  = idle_on;
    sink_idle_on = idle_on;
    span = ledger.active_words() * WORD_SIZE;
    for (int n = 0; n < items; n++) begin
      if (hold && n == 5) long_hold_req = 1'b1;
      if (n == items / 2 && $urandom_range(0, 1) == 1) drain();
      act = ($urandom_range(1, 100) <= alloc_pct) ? bsa_pkg::ACT_ALLOC
                                                  : bsa_pkg::ACT_RELEASE;
      // mostly in-range releases, the rest anywhere in the field
      if (span > 0 && $urandom_range(0, 4) != 0)
        idx = bsa_pkg::SLOT_W'($urandom_range(0, span - 1));
      else
        idx = bsa_pkg::SLOT_W'($urandom());
      push_request(act, idx);
    end
  endtask

  // Run limit
  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    ledger = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_action <= bsa_pkg::ACT_ALLOC;
    in_slot   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    src_idle_on   = 1'b0;
    sink_idle_on  = 1'b0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: grants, release of taken and free slots, top index
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_ALLOC, '1);
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_RELEASE, bsa_pkg::SLOT_W'(1));
    push_request(bsa_pkg::ACT_RELEASE, bsa_pkg::SLOT_W'(1));
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_RELEASE, '1);
    push_request(bsa_pkg::ACT_RELEASE, '0);
    push_request(bsa_pkg::ACT_ALLOC, '0);
    // empty pool: every allocate fails, every release is out of range
    drain();
    write_slot_count('0);
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_RELEASE, '0);
    push_request(bsa_pkg::ACT_RELEASE, '1);
    // partial word only: still no usable slot
    drain();
    write_slot_count(bsa_pkg::CNT_W'(31));
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_RELEASE, '0);
    // one word plus a stray slot
    drain();
    write_slot_count(bsa_pkg::CNT_W'(33));
    push_request(bsa_pkg::ACT_RELEASE, bsa_pkg::SLOT_W'(32));
    push_request(bsa_pkg::ACT_RELEASE, bsa_pkg::SLOT_W'(31));
    push_request(bsa_pkg::ACT_ALLOC, '0);
    // oversized count saturates at the full bitmap
    drain();
    write_slot_count('1);
    push_request(bsa_pkg::ACT_ALLOC, '0);
    push_request(bsa_pkg::ACT_RELEASE, '1);
    push_request(bsa_pkg::ACT_RELEASE, bsa_pkg::SLOT_W'(512));

    // Random phases: several sizes, shrinking and regrowing the pool
    run_phase(bsa_pkg::CNT_W'(1024), 270, 75, 1'b1, 1'b1);
    run_phase(bsa_pkg::CNT_W'(32),   150, 55, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'(64),   150, 60, 1'b1, 1'b0);
    run_phase('1,                    150, 70, 1'b1, 1'b1);
    run_phase('0,                     60, 50, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'(96),   150, 55, 1'b0, 1'b0);
    run_phase(bsa_pkg::CNT_W'(1024), 200, 60, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'(33),   120, 60, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'($urandom_range(0, 2047)), 200, 50, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'(1023), 150, 65, 1'b1, 1'b0);
    run_phase(bsa_pkg::CNT_W'(32),   150, 50, 1'b1, 1'b0);
    // last stretch runs with no idling on either side
    run_phase(bsa_pkg::CNT_W'(1024), 200, 50, 1'b0, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
